@@ rtl/core/rll_pkg.sv @@
// Package for the recurrent linear layer step block.
// Holds the transaction payload types, mode codes, sequencer states and
// fixed arithmetic constants; no dependencies.
`timescale 1ns / 1ps

package rll_pkg;

  // fixed widths of the payload fields
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned OUT_IDX_W  = 6;

  // gene store geometry and arithmetic constants
  localparam int unsigned GENE_DEPTH = 256;
  localparam int unsigned GENE_W     = 7;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned PROD_W     = DATA_W + WEIGHT_W;
  localparam int unsigned GENE_MOD   = 100;
  localparam int unsigned GENE_HALF  = GENE_MOD / 2;
  localparam int unsigned GENE_BIAS  = 50;
  localparam int unsigned ROW_SCALE  = 50;
  localparam int unsigned DIVISOR_W  = 7;

  // constant divider: one dividend byte per step, quotient digit found by
  // multiplying with the scaled reciprocal of ROW_SCALE
  localparam int unsigned        DIG_W     = 8;
  localparam int unsigned        RECIP_W   = 15;
  localparam int unsigned        RECIP_SH  = 20;
  localparam logic [RECIP_W-1:0] ROW_RECIP = 15'd20972;

  typedef enum logic [1:0] {
    MODE_GENE  = 2'd0,
    MODE_INPUT = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GENE,
    S_ISSUE,
    S_ACCUM,
    S_DIVIDE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]                mode;
    logic [INDEX_W-1:0]        index;
    logic signed [DATA_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]      out_index;
    logic signed [DATA_W-1:0]  out_value;
    logic                      last;
  } out_t;

  // control that travels alongside each multiply-accumulate operand pair
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

@@ rtl/core/rll_mac.sv @@
// Shared multiply-accumulate unit: one weight times one node value per cycle.
// Registered product stage, then a registered accumulator. Uses rll_pkg.
`timescale 1ns / 1ps

module rll_mac import rll_pkg::*; #(
  parameter int unsigned ACC_W = 44
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctl_t                   ctl_i,
  input  logic signed [WEIGHT_W-1:0] weight_i,
  input  logic signed [DATA_W-1:0]   x_i,
  output logic signed [ACC_W-1:0]    acc_o,
  output logic                       done_o
);

  mac_ctl_t                  ctl_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_d;
  logic                      done_q;

  // product stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ctl_q  <= ctl_i;
      done_q <= ctl_q.valid & ctl_q.last;
    end
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= PROD_W'(weight_i) * PROD_W'(x_i);
    end
  end

  // accumulate, restarting on the first column of a row
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_d    = ctl_q.first ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i) begin
    if (ctl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

@@ rtl/core/rll_cdiv.sv @@
// Shared divider by the constant ROW_SCALE, one dividend byte per cycle.
// Each step finds a quotient digit by reciprocal multiplication. Uses rll_pkg.
`timescale 1ns / 1ps

module rll_cdiv import rll_pkg::*; #(
  parameter int unsigned MAG_W = 44
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [MAG_W-1:0]      dividend_i,
  output logic                  done_o,
  output logic [MAG_W-1:0]      quot_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  localparam int unsigned STEPS  = (MAG_W + DIG_W - 1) / DIG_W;
  localparam int unsigned PAD_W  = STEPS * DIG_W;
  localparam int unsigned CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned PART_W = DIVISOR_W + DIG_W;
  localparam int unsigned MUL_W  = PART_W + RECIP_W;

  logic                  run_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [PAD_W-1:0]      quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [PART_W-1:0]     part;
  logic [MUL_W-1:0]      prod;
  logic [DIG_W-1:0]      digit;
  logic [PART_W-1:0]     part_rem;

  // one step: running remainder and next byte, digit from the reciprocal
  assign part     = {rem_q, quo_q[PAD_W-1 -: DIG_W]};
  assign prod     = MUL_W'(part) * MUL_W'(ROW_RECIP);
  assign digit    = prod[RECIP_SH +: DIG_W];
  assign part_rem = part - PART_W'(digit) * PART_W'(ROW_SCALE);

  // sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(STEPS - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient digits shift in where dividend bytes shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= PAD_W'(dividend_i);
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[PAD_W-DIG_W-1:0], digit};
      rem_q <= part_rem[DIVISOR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[MAG_W-1:0];
  assign rem_o  = rem_q;

endmodule

@@ rtl/core/recurrent_linear_layer_step.sv @@
// Top level of the recurrent linear layer step: sequencer, gene store,
// node buffer and output register. Depends on rll_pkg, rll_mac, rll_cdiv.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------------------
//   input   | in_valid_i / in_ready_o   | in_i  (mode, index, value)
//   output  | out_valid_o / out_ready_i | out_o (out_index, out_value, last)
//
// Input write and buffer clear are handled from the idle state; a gene write
// is paced by the byte-wide divider. A tick is paced by the single MAC unit
// (one column per cycle) and the divider. Reset clears the node buffer and
// control; the gene store holds garbage until written. An output stall holds
// the sequencer at the row that has to emit.
`timescale 1ns / 1ps

module recurrent_linear_layer_step import rll_pkg::*; #(
  parameter int unsigned NUM_INPUTS    = 8,
  parameter int unsigned NUM_RECURRENT = 8,
  parameter int unsigned NUM_OUTPUTS   = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int unsigned COLS    = NUM_INPUTS + NUM_RECURRENT;
  localparam int unsigned ROWS    = NUM_RECURRENT + NUM_OUTPUTS;
  localparam int unsigned COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned POS_RAW = $clog2(ROWS * COLS + 1);
  localparam int unsigned POS_W   = (POS_RAW > 9) ? POS_RAW : 9;
  localparam int unsigned FRESH_N = (NUM_RECURRENT > 0) ? NUM_RECURRENT : 1;
  localparam int unsigned FR_W    = (FRESH_N > 1) ? $clog2(FRESH_N) : 1;
  localparam int unsigned ACC_W   = PROD_W + COL_W;
  localparam int unsigned GADDR_W = $clog2(GENE_DEPTH);

  state_e state_q, state_d;

  // sequencer counters and latched item
  logic [COL_W-1:0]            col_q;
  logic [ROW_W-1:0]            row_q;
  logic [POS_W-1:0]            pos_q;
  logic [GADDR_W-1:0]          gidx_q;
  logic                        gneg_q;
  logic                        aneg_q;

  // storage
  logic [GENE_W-1:0]           gene_mem [GENE_DEPTH];
  logic [GENE_W-1:0]           gene_rd_q;
  logic signed [DATA_W-1:0]    x_q [COLS];
  logic signed [DATA_W-1:0]    x_rd_q;
  logic signed [DATA_W-1:0]    fresh_q [FRESH_N];
  logic                        in_range_q;
  mac_ctl_t                    ctl_q;

  // output register
  logic                        out_valid_q;
  out_t                        out_q;

  // decoded strobes
  logic in_acc;
  logic issue;
  logic last_col;
  logic last_row;
  logic rec_row;
  logic slot_free;
  logic row_step;
  logic gene_we;
  logic div_start;

  // unit interfaces
  logic signed [ACC_W-1:0]     acc;
  logic                        mac_done;
  logic                        div_done;
  logic [ACC_W-1:0]            quot;
  logic [DIVISOR_W-1:0]        rem;
  logic [ACC_W-1:0]            div_dividend;
  mac_ctl_t                    ctl_d;
  logic signed [WEIGHT_W-1:0]  weight;

  logic signed [ACC_W-1:0]     val_ext;
  logic [ACC_W-1:0]            val_mag;
  logic [ACC_W-1:0]            acc_mag;
  logic [GENE_W-1:0]           gene_mag;
  logic [GENE_W-1:0]           gene_new;
  logic signed [DATA_W-1:0]    row_val;
  logic                        sat_hi;
  logic                        sat_lo;
  logic                        in_idx_ok;

  assign in_acc    = in_valid_i & in_ready_o;
  assign last_col  = col_q == COL_W'(COLS - 1);
  assign last_row  = row_q == ROW_W'(ROWS - 1);
  assign rec_row   = row_q < ROW_W'(NUM_RECURRENT);
  assign slot_free = ~out_valid_q | out_ready_i;
  assign in_idx_ok = in_i.index < INDEX_W'(NUM_INPUTS);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.mode == MODE_GENE) begin
            state_d = S_GENE;
          end else if (in_i.mode == MODE_TICK) begin
            state_d = S_ISSUE;
          end
        end
      end
      S_GENE: begin
        if (div_done) state_d = S_IDLE;
      end
      S_ISSUE: begin
        if (last_col) state_d = S_ACCUM;
      end
      S_ACCUM: begin
        if (mac_done) state_d = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (div_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (rec_row || slot_free) begin
          state_d = last_row ? S_IDLE : S_ISSUE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output decode
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    gene_we    = 1'b0;
    div_start  = 1'b0;
    row_step   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = in_acc && (in_i.mode == MODE_GENE);
      end
      S_GENE:   gene_we   = div_done;
      S_ISSUE:  issue     = 1'b1;
      S_ACCUM:  div_start = mac_done;
      S_DIVIDE: ;
      S_FINISH: row_step  = rec_row | slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // row and column counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pos_q <= '0;
    end else if (in_acc) begin
      col_q <= '0;
      row_q <= '0;
      pos_q <= '0;
    end else begin
      if (issue) begin
        col_q <= last_col ? '0 : col_q + 1'b1;
        pos_q <= pos_q + 1'b1;
      end
      if (row_step) begin
        row_q <= row_q + 1'b1;
      end
    end
  end

  // gene magnitude for the mod-100 reduction
  assign val_ext = {{(ACC_W-DATA_W){in_i.value[DATA_W-1]}}, in_i.value};
  assign val_mag = in_i.value[DATA_W-1] ? ACC_W'(-val_ext) : ACC_W'(val_ext);
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  // divider operand select
  assign div_dividend = (state_q == S_IDLE) ? val_mag : acc_mag;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      gidx_q <= in_i.index;
      gneg_q <= in_i.value[DATA_W-1];
    end
    if (state_q == S_ACCUM && mac_done) begin
      aneg_q <= acc[ACC_W-1];
    end
  end

  // magnitude mod 100 from the mod-50 remainder and the quotient parity
  assign gene_mag = GENE_W'(rem) + (quot[0] ? GENE_W'(GENE_HALF) : '0);

  // negative values wrap upward into 0..99
  assign gene_new = (gneg_q && gene_mag != '0) ? GENE_W'(GENE_MOD) - gene_mag : gene_mag;

  // gene store, registered read
  always_ff @(posedge clk_i) begin
    if (gene_we) begin
      gene_mem[gidx_q] <= gene_new;
    end
    gene_rd_q <= gene_mem[pos_q[GADDR_W-1:0]];
  end

  // operand fetch alignment with the registered gene read
  always_comb begin
    ctl_d       = '0;
    ctl_d.valid = issue;
    ctl_d.first = col_q == '0;
    ctl_d.last  = last_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl_q <= '0;
    else         ctl_q <= ctl_d;
  end

  always_ff @(posedge clk_i) begin
    x_rd_q     <= x_q[col_q];
    in_range_q <= pos_q < POS_W'(GENE_DEPTH);
  end

  // weight is gene minus bias; positions past the store weigh zero
  assign weight = in_range_q ? WEIGHT_W'($signed({1'b0, gene_rd_q})) - WEIGHT_W'(GENE_BIAS)
                             : '0;

  rll_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_q),
    .weight_i (weight),
    .x_i      (x_rd_q),
    .acc_o    (acc),
    .done_o   (mac_done)
  );

  rll_cdiv #(
    .MAG_W (ACC_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // sign and saturate the row quotient
  assign sat_hi  = ~aneg_q & (quot[ACC_W-1:DATA_W-1] != '0);
  assign sat_lo  = aneg_q & ((quot[ACC_W-1:DATA_W] != '0) ||
                   (quot[DATA_W-1] && quot[DATA_W-2:0] != '0));
  always_comb begin
    if (sat_hi) begin
      row_val = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sat_lo) begin
      row_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (aneg_q) begin
      row_val = -$signed(quot[DATA_W-1:0]);
    end else begin
      row_val = $signed(quot[DATA_W-1:0]);
    end
  end

  // staging for new recurrent values until the tick ends
  always_ff @(posedge clk_i) begin
    if (row_step && rec_row) begin
      fresh_q[row_q[FR_W-1:0]] <= row_val;
    end
  end

  // node buffer: input writes, clear, and recurrent commit at the end of a tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COLS; i++) x_q[i] <= '0;
    end else begin
      if (in_acc && in_i.mode == MODE_INPUT && in_idx_ok) begin
        x_q[in_i.index[COL_W-1:0]] <= in_i.value;
      end
      if (in_acc && in_i.mode == MODE_CLEAR) begin
        for (int i = 0; i < COLS; i++) x_q[i] <= '0;
      end
      if (row_step && last_row) begin
        for (int j = 0; j < NUM_RECURRENT; j++) x_q[NUM_INPUTS + j] <= fresh_q[j];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (row_step && !rec_row) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_step && !rec_row) begin
      out_q.out_index <= OUT_IDX_W'(row_q - ROW_W'(NUM_RECURRENT));
      out_q.out_value <= row_val;
      out_q.last      <= last_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
